// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

  // Field widths of the input and result beats
  localparam int FUNC_W = 2;
  localparam int IVL_W  = 16;
  localparam int SLOT_W = 3;
  localparam int TICK_W = 16;
  localparam int KIND_W = 3;

  // Default table size
  localparam int DEF_TASK_SLOTS = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXEC   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

endpackage

// ===== hw/rtl/pts_in_if.sv =====
interface pts_in_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IVL_W-1:0]  interval;
  logic [SLOT_W-1:0] slot;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, func, interval, slot, now_tick, input ready);
  modport sink   (input valid, func, interval, slot, now_tick, output ready);
endinterface

// ===== hw/rtl/pts_out_if.sv =====
interface pts_out_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] task_slot;
  logic              last;

  modport source (output valid, kind, task_slot, last, input ready);
  modport sink   (input valid, kind, task_slot, last, output ready);
endinterface

// ===== hw/rtl/pts_ram.sv =====
module pts_ram import pts_pkg::*; #(
  parameter int DEPTH = DEF_TASK_SLOTS,
  parameter int AW    = 3,
  parameter int DW    = IVL_W + TICK_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/periodic_task_slot_scheduler.sv =====
// Periodic task slot scheduler.
// in_bus carries one command beat: add (interval), remove (slot) or execute
// (now_tick); operation code 3 is dropped without a result. out_bus returns
// result beats (kind, task_slot, last); last marks the final beat of a command.
// Add and remove are taken on accept; the result is registered and shows
// on out_bus the cycle after. Execute walks the slot table in a RAM with one
// read and one write port, one slot per cycle unless a stalled out_bus holds
// the scan. Back-to-back add/remove beats run at one per cycle while out_bus
// takes each result; no new command is taken until an execute has issued its
// final beat.
// A due slot is held in the pend register until the next due slot or the scan
// end, so that last can be set on the final one; a stalled out_bus freezes the
// scan only when a second due beat must leave. in_bus.ready drops during a
// scan and while a result waits with ready low. Reset (rst_n low, synchronous)
// clears all valid bits and the output register; the RAM contents are only
// used for valid slots and need no clearing pass.
module periodic_task_slot_scheduler import pts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic clk,
  input  logic rst_n,
  pts_in_if.sink    in_bus,
  pts_out_if.source out_bus
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int DW    = IVL_W + TICK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]            state_r, state_nxt;
  logic [TASK_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  iss_r, iss_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic [TICK_W-1:0]     now_r, now_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;
  logic [IVL_W-1:0]  rd_ivl;
  logic [TICK_W-1:0] rd_last, delta;

  logic             in_fire, out_free, due, stall, scan_done, advance;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Due check on the slot whose entry the RAM read register holds
  assign rd_ivl  = ram_rdata[DW-1:TICK_W];
  assign rd_last = ram_rdata[TICK_W-1:0];
  assign delta   = now_r - rd_last;
  assign due     = chk_v_r && valid_r[chk_idx_r] && (delta >= rd_ivl);

  assign out_free  = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign stall     = due && pend_v_r && !out_free;
  assign scan_done = !iss_r && !chk_v_r;
  assign advance   = (state_r == S_SCAN) && !stall && !scan_done;
  assign ram_re    = advance && iss_r;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_wdata     = {rd_ivl, now_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_bus.func)
            FUNC_ADD: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (free_found) begin
                valid_nxt[free_idx] = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = free_idx;
                ram_wdata     = {in_bus.interval, TICK_W'(0)};
                out_kind_nxt  = KIND_ADDED;
                out_slot_nxt  = SLOT_W'(free_idx);
              end else begin
                out_kind_nxt  = KIND_FULL;
                out_slot_nxt  = '0;
              end
            end
            FUNC_REMOVE: begin
              if (32'(in_bus.slot) < 32'(TASK_SLOTS)) begin
                valid_nxt[IDX_W'(in_bus.slot)] = 1'b0;
              end
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_kind_nxt  = KIND_REMOVED;
              out_slot_nxt  = in_bus.slot;
            end
            FUNC_EXEC: begin
              state_nxt  = S_SCAN;
              idx_nxt    = '0;
              iss_nxt    = 1'b1;
              chk_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              now_nxt    = in_bus.now_tick;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      S_SCAN: begin
        if (advance) begin
          // Pipeline: issue read of idx_r, check chk_idx_r
          chk_v_nxt   = iss_r;
          chk_idx_nxt = idx_r;
          if (iss_r) begin
            idx_nxt = idx_r + 1'b1;
            iss_nxt = (idx_r != LAST_IDX);
          end
          if (due) begin
            ram_we       = 1'b1;
            ram_waddr    = chk_idx_r;
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = chk_idx_r;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_DUE;
              out_slot_nxt  = SLOT_W'(pend_idx_r);
              out_last_nxt  = 1'b0;
            end
          end
        end else if (scan_done && out_free) begin
          // Final beat of the scan
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = pend_v_r ? KIND_DUE : KIND_IDLE;
          out_slot_nxt  = pend_v_r ? SLOT_W'(pend_idx_r) : '0;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      iss_r       <= 1'b0;
      chk_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      iss_r       <= iss_nxt;
      chk_v_r     <= chk_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  // Interval / last-run table
  pts_ram #(
    .DEPTH (TASK_SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_bus.valid     = out_valid_r;
  assign out_bus.kind      = out_kind_r;
  assign out_bus.task_slot = out_slot_r;
  assign out_bus.last      = out_last_r;

  // A successful add claims exactly one more slot
  a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_bus.func == FUNC_ADD) && free_found |=>
      $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("add did not claim exactly one slot");

  // Valid bits do not move while a scan is in flight
  a_scan_valid_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && $past(state_r == S_SCAN) |-> $stable(valid_r))
    else $error("valid bits changed during scan");

  // Table writes only come from an add or a due slot in the scan
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_fire && (in_bus.func == FUNC_ADD)) || (advance && due))
    else $error("unexpected table write");

endmodule

// ===== tb/sv/periodic_task_slot_scheduler_test.sv =====
`timescale 1ns / 1ps

module periodic_task_slot_scheduler_test;
  import pts_pkg::*;

  localparam int TASK_SLOTS = DEF_TASK_SLOTS;

  // Operation code the block drops without a result
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // How a directed row is checked
  localparam bit TYPED   = 1'b1;
  localparam bit MODELED = 1'b0;

  localparam int RAND_CMDS    = 400;
  localparam int CALM_CMDS    = 120;
  localparam int HOLD_AT      = 160;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 14;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_CYCLES   = 200000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IVL_W-1:0]  interval;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] now_tick;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] task_slot;
    logic              last;
  } report_t;

  typedef struct packed {
    bit      typed;
    cmd_t    cmd;
    report_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  pts_in_if  cmd_bus ();
  pts_out_if rpt_bus ();

  periodic_task_slot_scheduler #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (cmd_bus),
    .out_bus(rpt_bus)
  );

  always #1 clk = ~clk;

  // Shadow copy of the slot table
  logic [TASK_SLOTS-1:0] slot_live = '0;
  logic [IVL_W-1:0]      slot_period [TASK_SLOTS];
  logic [TICK_W-1:0]     slot_ran_at [TASK_SLOTS];

  report_t     owed_reports[$];
  int          err_cnt = 0;
  int unsigned cycles  = 0;
  bit          calm    = 1'b0;
  bit          hold_go = 1'b0;

  // Apply one command to the shadow table; queue its report beats when asked
  task automatic forecast(input cmd_t c, input bit keep);
    report_t           rs[$];
    report_t           r;
    logic [TICK_W-1:0] elapsed;
    bit                found;
    int                i;
    found = 1'b0;
    r = '0;
    case (c.func)
      FUNC_ADD: begin
        for (i = 0; i < TASK_SLOTS; i++) begin
          if (!found && !slot_live[i]) begin
            found          = 1'b1;
            slot_live[i]   = 1'b1;
            slot_period[i] = c.interval;
            slot_ran_at[i] = '0;
            r.kind         = KIND_ADDED;
            r.task_slot    = SLOT_W'(i);
          end
        end
        if (!found) begin
          r.kind      = KIND_FULL;
          r.task_slot = '0;
        end
        rs.push_back(r);
      end
      FUNC_REMOVE: begin
        if (int'(c.slot) < TASK_SLOTS) slot_live[c.slot] = 1'b0;
        r.kind      = KIND_REMOVED;
        r.task_slot = c.slot;
        rs.push_back(r);
      end
      FUNC_EXEC: begin
        for (i = 0; i < TASK_SLOTS; i++) begin
          if (slot_live[i]) begin
            // wrapping tick difference
            elapsed = c.now_tick - slot_ran_at[i];
            if (elapsed >= slot_period[i]) begin
              slot_ran_at[i] = c.now_tick;
              r.kind         = KIND_DUE;
              r.task_slot    = SLOT_W'(i);
              rs.push_back(r);
            end
          end
        end
        if (rs.size() == 0) begin
          r.kind      = KIND_IDLE;
          r.task_slot = '0;
          rs.push_back(r);
        end
      end
      default: ;
    endcase
    if (rs.size() != 0) begin
      r = rs.pop_back();
      r.last = 1'b1;
      rs.push_back(r);
    end
    if (keep) begin
      foreach (rs[k]) owed_reports.push_back(rs[k]);
    end
  endtask

  // Offer one command beat, with an occasional gap before it
  task automatic issue(input cmd_t c, input bit typed, input report_t want);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= c.func;
    cmd_bus.interval <= c.interval;
    cmd_bus.slot     <= c.slot;
    cmd_bus.now_tick <= c.now_tick;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    forecast(c, !typed);
    if (typed) owed_reports.push_back(want);
  endtask

  function automatic row_t row(input bit typed, input logic [FUNC_W-1:0] f,
                               input logic [IVL_W-1:0] ivl,
                               input logic [SLOT_W-1:0] s,
                               input logic [TICK_W-1:0] t,
                               input logic [KIND_W-1:0] k,
                               input logic [SLOT_W-1:0] ks);
    row_t x;
    x.typed          = typed;
    x.cmd.func       = f;
    x.cmd.interval   = ivl;
    x.cmd.slot       = s;
    x.cmd.now_tick   = t;
    x.want.kind      = k;
    x.want.task_slot = ks;
    x.want.last      = 1'b1;
    return x;
  endfunction

  task automatic note_bad(input string what, input int want_v, input int got_v);
    err_cnt++;
    if (err_cnt <= REPORT_LIMIT)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want_v, got_v);
  endtask

  // Result sink: random stalls, one long hold-off, a calm stretch
  initial begin : rpt_sink
    int k;
    bit held;
    held = 1'b0;
    rpt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        rpt_bus.ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        rpt_bus.ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each accepted report beat with the oldest one owed
  always @(posedge clk) begin
    report_t want;
    if (rst_n === 1'b1 && rpt_bus.valid === 1'b1 && rpt_bus.ready === 1'b1) begin
      if (owed_reports.size() == 0) begin
        note_bad("unexpected beat, kind", -1, int'(rpt_bus.kind));
      end else begin
        want = owed_reports.pop_front();
        if (rpt_bus.kind !== want.kind)
          note_bad("kind", int'(want.kind), int'(rpt_bus.kind));
        if (rpt_bus.task_slot !== want.task_slot)
          note_bad("task_slot", int'(want.task_slot), int'(rpt_bus.task_slot));
        if (rpt_bus.last !== want.last)
          note_bad("last", int'(want.last), int'(rpt_bus.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    row_t              plan[$];
    cmd_t              c;
    logic [TICK_W-1:0] tick;
    logic [IVL_W-1:0]  add_ivl [TASK_SLOTS];
    int                sent;
    int                pick;
    int                i;
    add_ivl = '{16'h0000, 16'hFFFF, 16'd1, 16'd100, 16'h8000, 16'd5, 16'd2, 16'd3};

    rst_n            <= 1'b0;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.func     <= FUNC_ADD;
    cmd_bus.interval <= '0;
    cmd_bus.slot     <= '0;
    cmd_bus.now_tick <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: nothing due; remove of a free slot still reports
    plan.push_back(row(TYPED, FUNC_EXEC, 16'hFFFF, 3'd7, 16'h0000, KIND_IDLE, 3'd0));
    plan.push_back(row(TYPED, FUNC_REMOVE, 16'h0000, 3'd7, 16'hFFFF, KIND_REMOVED, 3'd7));
    // Fill every slot, zero and maximum interval among them, then overflow
    for (i = 0; i < TASK_SLOTS; i++)
      plan.push_back(row(TYPED, FUNC_ADD, add_ivl[i], 3'd0, 16'h0000, KIND_ADDED,
                         SLOT_W'(i)));
    plan.push_back(row(TYPED, FUNC_ADD, 16'h00FF, 3'd7, 16'hFFFF, KIND_FULL, 3'd0));
    // Unused code gives nothing
    plan.push_back(row(MODELED, FUNC_UNUSED, 16'hFFFF, 3'd7, 16'hFFFF, KIND_IDLE, 3'd0));
    // Scans: all due at top tick, then only zero interval, then wrap
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'hFFFF, KIND_IDLE, 3'd0));
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'hFFFF, KIND_IDLE, 3'd0));
    plan.push_back(row(TYPED, FUNC_REMOVE, 16'h0000, 3'd0, 16'h0000, KIND_REMOVED, 3'd0));
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'h0000, KIND_IDLE, 3'd0));
    plan.push_back(row(TYPED, FUNC_ADD, 16'h1234, 3'd0, 16'h0000, KIND_ADDED, 3'd0));
    plan.push_back(row(TYPED, FUNC_REMOVE, 16'h0000, 3'd3, 16'h0000, KIND_REMOVED, 3'd3));
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'h7FFF, KIND_IDLE, 3'd0));
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'h8000, KIND_IDLE, 3'd0));
    plan.push_back(row(MODELED, FUNC_EXEC, 16'h0000, 3'd0, 16'h8005, KIND_IDLE, 3'd0));

    foreach (plan[j]) issue(plan[j].cmd, plan[j].typed, plan[j].want);

    // Random mix; ticks mostly creep forward so tasks come due now and then
    tick = 16'h8005;
    sent = 0;
    calm <= 1'b1;
    while (sent < RAND_CMDS) begin
      if (sent == CALM_CMDS) calm <= 1'b0;
      if (sent == HOLD_AT) hold_go <= 1'b1;
      c.interval = IVL_W'($urandom);
      c.slot     = SLOT_W'($urandom);
      c.now_tick = TICK_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) begin
        c.func = FUNC_UNUSED;
      end else if (pick < 30) begin
        c.func = FUNC_ADD;
        pick = $urandom_range(9);
        if (pick < 2)      c.interval = IVL_W'($urandom_range(15));
        else if (pick < 9) c.interval = IVL_W'($urandom_range(300));
      end else if (pick < 55) begin
        c.func = FUNC_REMOVE;
      end else begin
        c.func = FUNC_EXEC;
        if ($urandom_range(19) == 0) tick = TICK_W'($urandom);
        else                         tick = tick + TICK_W'($urandom_range(120));
        c.now_tick = tick;
      end
      issue(c, 1'b0, '0);
      if (c.func != FUNC_UNUSED) sent++;
    end

    // Drain
    cmd_bus.valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (TASK_SLOTS + 4) @(posedge clk);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
